[rtl/deadline_job_scheduler_macros.svh]
// Assertion macros shared by the deadline job scheduler RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef DEADLINE_JOB_SCHEDULER_MACROS_SVH
`define DEADLINE_JOB_SCHEDULER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DJS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DJS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/djs_pkg.sv]
// Package for the deadline job scheduler: field widths and the job record type.
// No dependencies.
`timescale 1ns / 1ps

package djs_pkg;

	localparam int ID_W         = 8;
	localparam int DL_W         = 16;
	localparam int PR_W         = 31;
	localparam int SLOT_W       = 5;
	localparam int MAX_JOBS_DEF = 32;

	typedef struct packed {
		logic [ID_W-1:0] id;
		logic [DL_W-1:0] deadline;
		logic [PR_W-1:0] profit;
	} job_t;

endpackage

[rtl/djs_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps

module djs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/deadline_job_scheduler.sv]
// Top level of the deadline job scheduler: load, profit sort, slot fill, emit.
// Depends on djs_pkg, djs_ram and deadline_job_scheduler_macros.svh.
`timescale 1ns / 1ps

`include "deadline_job_scheduler_macros.svh"

// Jobs are loaded one word per cycle while busy is low. The word with last_job
// raises busy until the batch's results are out. For a batch of n jobs the profit
// sort runs on the single read port of the job memory (one comparison per cycle),
// the slot fill reads each job and searches down from its deadline for a free slot,
// and the emit pass reads the n slots in turn. Results come from the emit pass, one
// for each occupied slot and at most one per cycle, each in the cycle after its slot
// read; each is held for one cycle with strobe high and the receiver must take it.
module deadline_job_scheduler import djs_pkg::*; #(
	parameter int MAX_JOBS = MAX_JOBS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [ID_W-1:0]   job_id,
	input  logic [DL_W-1:0]   job_deadline,
	input  logic [PR_W-1:0]   job_profit,
	input  logic              last_job,
	output logic              strobe,
	output logic [ID_W-1:0]   sched_id,
	output logic [SLOT_W-1:0] sched_slot,
	output logic              sched_last
);

	localparam int IW = $clog2(MAX_JOBS);
	localparam int CW = $clog2(MAX_JOBS + 1);
	localparam int JW = $bits(job_t);

	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_SORT_I   = 4'd1;
	localparam logic [3:0] ST_SORT_CUR = 4'd2;
	localparam logic [3:0] ST_SORT_J   = 4'd3;
	localparam logic [3:0] ST_SORT_WB  = 4'd4;
	localparam logic [3:0] ST_ASG_RD   = 4'd5;
	localparam logic [3:0] ST_ASG_D    = 4'd6;
	localparam logic [3:0] ST_ASG_SCAN = 4'd7;
	localparam logic [3:0] ST_EMIT     = 4'd8;
	localparam logic [3:0] ST_DRAIN    = 4'd9;

	logic [3:0]          state_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       n_q;
	logic [CW-1:0]       i_q;
	logic [CW-1:0]       j_q;
	logic [CW-1:0]       s_q;
	job_t                cur_q;
	logic [ID_W-1:0]     id_q;
	logic [MAX_JOBS-1:0] taken_q;
	logic [IW-1:0]       last_q;
	logic                v_s1;
	logic [IW-1:0]       slot_s1;
	logic                last_s1;

	logic [CW-1:0] i_inc, j_inc, s_dec, n_next;
	logic [IW-1:0] s_idx;
	logic          full, accept, gt;

	logic          job_we;
	logic [IW-1:0] job_waddr, job_raddr;
	job_t          job_wdata, job_rd;
	logic [JW-1:0] job_rdata;

	logic            slot_we;
	logic [ID_W-1:0] slot_rdata;

	assign i_inc  = i_q + 1'b1;
	assign j_inc  = j_q + 1'b1;
	assign s_dec  = s_q - 1'b1;
	assign s_idx  = s_dec[IW-1:0];
	assign full   = (count_q == CW'(MAX_JOBS));
	assign n_next = full ? count_q : count_q + 1'b1;
	assign accept = start && !busy;
	assign job_rd = job_t'(job_rdata);
	assign gt     = (job_rd.profit > cur_q.profit);

	assign busy       = (state_q != ST_IDLE);
	assign strobe     = v_s1;
	assign sched_id   = slot_rdata;
	assign sched_slot = SLOT_W'(slot_s1);
	assign sched_last = v_s1 && last_s1;

	// The sort holds the entry at i in cur_q and swaps through the j entries,
	// so each comparison needs only one memory read.
	always_comb begin
		job_we    = 1'b0;
		job_waddr = i_q[IW-1:0];
		job_wdata = cur_q;
		job_raddr = i_q[IW-1:0];
		unique case (state_q)
			ST_IDLE: begin
				job_we    = accept && !full;
				job_waddr = count_q[IW-1:0];
				job_wdata = '{id: job_id, deadline: job_deadline, profit: job_profit};
			end
			ST_SORT_CUR: begin
				job_raddr = i_inc[IW-1:0];
			end
			ST_SORT_J: begin
				job_we    = gt;
				job_waddr = j_q[IW-1:0];
				job_raddr = j_inc[IW-1:0];
			end
			ST_SORT_WB: begin
				job_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign slot_we = (state_q == ST_ASG_SCAN) && (s_q != '0) && !taken_q[s_idx];

	djs_ram #(
		.WIDTH(JW),
		.DEPTH(MAX_JOBS)
	) u_job_ram (
		.clk  (clk),
		.we   (job_we),
		.waddr(job_waddr),
		.wdata(job_wdata),
		.raddr(job_raddr),
		.rdata(job_rdata)
	);

	djs_ram #(
		.WIDTH(ID_W),
		.DEPTH(MAX_JOBS)
	) u_slot_ram (
		.clk  (clk),
		.we   (slot_we),
		.waddr(s_idx),
		.wdata(id_q),
		.raddr(s_q[IW-1:0]),
		.rdata(slot_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			n_q     <= '0;
			i_q     <= '0;
			j_q     <= '0;
			s_q     <= '0;
			taken_q <= '0;
			last_q  <= '0;
			v_s1    <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_EMIT) && taken_q[s_q[IW-1:0]];
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (!full) begin
							count_q <= count_q + 1'b1;
						end
						if (last_job) begin
							n_q     <= n_next;
							i_q     <= '0;
							last_q  <= '0;
							state_q <= (n_next > CW'(1)) ? ST_SORT_I : ST_ASG_RD;
						end
					end
				end
				ST_SORT_I: begin
					state_q <= ST_SORT_CUR;
				end
				ST_SORT_CUR: begin
					j_q     <= i_inc;
					state_q <= ST_SORT_J;
				end
				ST_SORT_J: begin
					if (j_inc == n_q) begin
						state_q <= ST_SORT_WB;
					end else begin
						j_q <= j_inc;
					end
				end
				ST_SORT_WB: begin
					if (i_inc + 1'b1 < n_q) begin
						i_q     <= i_inc;
						state_q <= ST_SORT_I;
					end else begin
						i_q     <= '0;
						state_q <= ST_ASG_RD;
					end
				end
				ST_ASG_RD: begin
					state_q <= ST_ASG_D;
				end
				ST_ASG_D: begin
					if (job_rd.deadline > DL_W'(n_q)) begin
						s_q <= n_q;
					end else begin
						s_q <= CW'(job_rd.deadline);
					end
					state_q <= ST_ASG_SCAN;
				end
				ST_ASG_SCAN: begin
					if (s_q == '0 || !taken_q[s_idx]) begin
						if (s_q != '0) begin
							taken_q[s_idx] <= 1'b1;
							if (s_idx > last_q) begin
								last_q <= s_idx;
							end
						end
						if (i_inc == n_q) begin
							s_q     <= '0;
							state_q <= ST_EMIT;
						end else begin
							i_q     <= i_inc;
							state_q <= ST_ASG_RD;
						end
					end else begin
						s_q <= s_dec;
					end
				end
				ST_EMIT: begin
					if (s_q + 1'b1 == n_q) begin
						state_q <= ST_DRAIN;
					end else begin
						s_q <= s_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					taken_q <= '0;
					count_q <= '0;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers without reset.
	always_ff @(posedge clk) begin
		if (state_q == ST_SORT_CUR || (state_q == ST_SORT_J && gt)) begin
			cur_q <= job_rd;
		end
		if (state_q == ST_ASG_D) begin
			id_q <= job_rd.id;
		end
		slot_s1 <= s_q[IW-1:0];
		last_s1 <= (s_q[IW-1:0] == last_q);
	end

	`DJS_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(MAX_JOBS), "job count overflow")
	`DJS_ASSERT_IMP(a_sort_index, clk, arst_n, state_q == ST_SORT_J, (j_q > i_q) && (j_q < n_q), "sort index out of order")
	`DJS_ASSERT_IMP(a_scan_bound, clk, arst_n, state_q == ST_ASG_SCAN, s_q <= n_q, "slot scan beyond batch")
	`DJS_ASSERT_IMP(a_strobe_busy, clk, arst_n, strobe, busy, "result word outside a batch")
	`DJS_ASSERT_NXT(a_last_final, clk, arst_n, strobe && sched_last, !strobe, "result word after last")

endmodule
